// ----- design/bdr_pkg.sv -----
// package: shared types, codes and constants for the backlight duty ramp
package bdr_pkg;

  // field widths
  localparam int DutyW  = 7;
  localparam int DwellW = 8;
  localparam int StepW  = 8;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 2;

  // register reset values
  localparam logic [DwellW-1:0] DwellReset = 8'd20;
  localparam logic [DutyW-1:0]  SpanReset  = 7'd25;
  localparam logic [DutyW-1:0]  ScaleReset = 7'd100;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DWELL_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SPAN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FULL_SCALE  = 2'd2;

  // request actions
  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_SET    = 2'd2,
    ACT_INIT   = 2'd3
  } action_t;

  // ramp phases
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_ADJUSTING = 2'd1,
    PH_WAITING   = 2'd2,
    PH_ADJUSTED  = 2'd3
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1_GO,
    S_DIV1,
    S_DIV2_GO,
    S_DIV2,
    S_EXEC,
    S_EMIT
  } ctrl_state_t;

  // input request payload
  typedef struct packed {
    logic [1:0]       action;
    logic [DutyW-1:0] level;
  } item_t;

  // result payload
  typedef struct packed {
    logic [DutyW-1:0] duty_level;
    logic [DutyW-1:0] compare_value;
    logic [1:0]       phase;
    logic             finished;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic div_load;
    logic div_sel;    // 0: step size division, 1: remainder division
    logic div_step;
    logic exec;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic set_move;   // set target with nonzero distance
    logic div_last;   // divider in its last iteration
  } dp_status_t;

endpackage

// ----- design/backlight_duty_ramp_top.sv -----
// top level: backlight duty ramp controller and datapath
//
//  channel | signals                            | direction | request
//  item    | item_valid, item_stall, item       | in        | action, level
//  result  | result_valid, result_stall, result | out       | duty, compare, phase, finished
//  config  | cfg_we, cfg_index, cfg_data        | in        | register write
//
// update, tick and init requests step through accept, decode, state update, emit.
// set target with a nonzero distance adds two restoring divisions (step size,
// then remainder) on one shared bit-serial divider before the state update.
// reset (rst, synchronous) restores idle phase, zero duty and default registers.
// a stalled result holds in the output register; the next request is accepted
// meanwhile and waits at emit until the output register frees up.
module backlight_duty_ramp_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  bdr_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output bdr_pkg::result_t            result,
  input  logic                        cfg_we,
  input  logic [bdr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bdr_pkg::CfgW-1:0]    cfg_data
);
  import bdr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  bdr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic and state
  bdr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ----- design/bdr_ctrl.sv -----
// controller: sequences accept, divisions, state update and result hand-off
module bdr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  bdr_pkg::dp_status_t status,
  output bdr_pkg::dp_cmd_t    cmd
);
  import bdr_pkg::*;

  ctrl_state_t state, state_next;
  logic        slot_free;

  // state register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign slot_free  = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DIV1_GO;
        end
      end
      S_DIV1_GO: begin
        if (status.set_move) begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = 1'b0;
          state_next   = S_DIV1;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIV2_GO;
        end
      end
      S_DIV2_GO: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = 1'b1;
        state_next   = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a new result appears only out of the emit state
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> state == S_DIV1_GO)
    else $error("accepted request did not start");

  // first division always hands over to the second
  a_div_chain: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1 && status.div_last) |=> state == S_DIV2_GO)
    else $error("division chain broken");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result dropped");
`endif

endmodule

// ----- design/bdr_datapath.sv -----
// datapath: config registers, ramp state, shared divider and result register
module bdr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  bdr_pkg::item_t                 item,
  input  logic                           cfg_we,
  input  logic [bdr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bdr_pkg::CfgW-1:0]       cfg_data,
  input  bdr_pkg::dp_cmd_t               cmd,
  output bdr_pkg::dp_status_t            status,
  output bdr_pkg::result_t               result
);
  import bdr_pkg::*;

  // configuration
  logic [DwellW-1:0] dwell_ticks;
  logic [DutyW-1:0]  step_span;
  logic [DutyW-1:0]  full_scale;

  // ramp state
  phase_t            ramp_phase;
  logic [DutyW-1:0]  current_duty;
  logic [DutyW-1:0]  target_duty;
  logic [StepW-1:0]  step_size;
  logic [StepW-1:0]  final_step;
  logic [DwellW-1:0] dwell_count;
  logic [DutyW-1:0]  reported_duty;
  logic              finished;

  // latched request
  action_t           act;
  logic [DutyW-1:0]  lvl;

  // divider
  logic [StepW-1:0]  div_rem;
  logic [StepW-1:0]  div_quo;
  logic [StepW-1:0]  div_den;
  logic [2:0]        div_cnt;
  logic [StepW:0]    div_trial;
  logic [StepW-1:0]  st_mag;

  // derived values
  logic [DutyW-1:0]  lvl_sat;
  logic [DutyW:0]    delta;
  logic [DutyW-1:0]  mag;
  logic [DutyW-1:0]  span;
  logic [StepW-1:0]  fin_mag;
  logic [DutyW:0]    left_s;
  logic [DutyW-1:0]  left;
  logic [StepW:0]    step_s9;
  logic [StepW:0]    step_abs;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= DwellReset;
      step_span   <= SpanReset;
      full_scale  <= ScaleReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DWELL_TICKS: dwell_ticks <= cfg_data;
        CFG_STEP_SPAN:   step_span   <= cfg_data[DutyW-1:0];
        CFG_FULL_SCALE:  full_scale  <= cfg_data[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // saturate the incoming level to full scale
  assign lvl_sat = (item.level > full_scale) ? full_scale : item.level;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act <= action_t'(item.action);
      lvl <= lvl_sat;
    end
  end

  // signed distance to the new target and its magnitude
  assign delta  = {1'b0, lvl} - {1'b0, current_duty};
  assign mag    = delta[DutyW] ? DutyW'(-delta) : delta[DutyW-1:0];
  assign span   = (step_span == '0) ? DutyW'(1) : step_span;
  assign status.set_move = (act == ACT_SET) && (delta != '0);

  // restoring divider, one quotient bit per cycle
  assign div_trial = {div_rem, div_quo[StepW-1]} - {1'b0, div_den};
  assign status.div_last = (div_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_cnt <= '0;
      div_rem <= '0;
      if (!cmd.div_sel) begin
        div_quo <= {1'b0, mag} + {1'b0, span} - StepW'(1);
        div_den <= {1'b0, span};
      end else begin
        div_quo <= {1'b0, mag};
        div_den <= div_quo;
        st_mag  <= div_quo;
      end
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 3'd1;
      if (!div_trial[StepW]) begin
        div_rem <= div_trial[StepW-1:0];
        div_quo <= {div_quo[StepW-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[StepW-2:0], div_quo[StepW-1]};
        div_quo <= {div_quo[StepW-2:0], 1'b0};
      end
    end
  end

  // final step magnitude: remainder, or a full step when it divides evenly
  assign fin_mag = (div_rem == '0) ? st_mag : div_rem;

  // distance left and current step magnitude for the update action
  assign left_s   = {1'b0, target_duty} - {1'b0, current_duty};
  assign left     = left_s[DutyW] ? DutyW'(-left_s) : left_s[DutyW-1:0];
  assign step_s9  = {step_size[StepW-1], step_size};
  assign step_abs = step_s9[StepW] ? -step_s9 : step_s9;

  // ramp state update
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_phase    <= PH_IDLE;
      current_duty  <= '0;
      target_duty   <= '0;
      step_size     <= '0;
      final_step    <= '0;
      dwell_count   <= '0;
      reported_duty <= '0;
      finished      <= 1'b0;
    end else if (cmd.exec) begin
      finished <= 1'b0;
      case (act)
        ACT_UPDATE: begin
          case (ramp_phase)
            PH_ADJUSTING: begin
              if (current_duty != target_duty) begin
                if ({2'b0, left} < step_abs) begin
                  current_duty  <= current_duty + final_step[DutyW-1:0];
                  reported_duty <= current_duty + final_step[DutyW-1:0];
                  ramp_phase    <= PH_ADJUSTED;
                end else begin
                  current_duty  <= current_duty + step_size[DutyW-1:0];
                  reported_duty <= current_duty + step_size[DutyW-1:0];
                  dwell_count   <= dwell_ticks;
                  ramp_phase    <= PH_WAITING;
                end
              end else begin
                ramp_phase <= PH_ADJUSTED;
              end
            end
            PH_WAITING: begin
              if (dwell_count == '0) begin
                ramp_phase <= PH_ADJUSTING;
              end
            end
            PH_ADJUSTED: begin
              ramp_phase <= PH_IDLE;
              finished   <= 1'b1;
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          if (dwell_count != '0) begin
            dwell_count <= dwell_count - DwellW'(1);
          end
        end
        ACT_SET: begin
          target_duty <= lvl;
          if (delta != '0) begin
            step_size  <= delta[DutyW] ? -st_mag : st_mag;
            final_step <= delta[DutyW] ? -fin_mag : fin_mag;
            ramp_phase <= PH_ADJUSTING;
          end
        end
        ACT_INIT: begin
          current_duty  <= lvl;
          target_duty   <= lvl;
          reported_duty <= lvl;
          step_size     <= '0;
          ramp_phase    <= PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.duty_level    <= reported_duty;
      result.compare_value <= (reported_duty > full_scale) ? '0 : full_scale - reported_duty;
      result.phase         <= ramp_phase;
      result.finished      <= finished;
    end
  end

endmodule

// ----- tb/sv/backlight_duty_ramp_top_tb.sv -----
// testbench for the backlight duty ramp: directed and random requests against a ramp predictor
`timescale 1ns / 1ps

module backlight_duty_ramp_top_tb;
  import bdr_pkg::*;

  localparam int StuckLimit = 3000;
  localparam int MaxShown   = 10;

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  item_t              item;
  logic               result_valid;
  logic               result_stall;
  result_t            result;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  // predicted register contents
  logic [DwellW-1:0] reg_dwell = DwellReset;
  logic [DutyW-1:0]  reg_span  = SpanReset;
  logic [DutyW-1:0]  reg_scale = ScaleReset;

  // predicted ramp state
  phase_t            ramp_ph    = PH_IDLE;
  logic [DutyW-1:0]  duty_now   = '0;
  logic [DutyW-1:0]  duty_goal  = '0;
  logic [StepW-1:0]  step_amt   = '0;
  logic [StepW-1:0]  last_step  = '0;
  logic [DwellW-1:0] dwell_left = '0;
  logic [DutyW-1:0]  duty_shown = '0;

  // duty results still owed by the block, oldest first
  result_t owed_results[$];

  int bad_count    = 0;
  int stuck_cycles = 0;
  int hold_req     = 0;
  int hold_left    = 0;
  int rx_burst     = 0;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;

  backlight_duty_ramp_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ramp predictor: advances the state by one request and returns its result
  function automatic result_t next_duty_result(input item_t req);
    result_t          res;
    logic [DutyW-1:0] lvl;
    int               delta, mag, span, stp, rem, fin, left, sum;
    logic             done;
    done = 1'b0;
    lvl  = (req.level > reg_scale) ? reg_scale : req.level;
    case (action_t'(req.action))
      ACT_UPDATE: begin
        case (ramp_ph)
          PH_ADJUSTING: begin
            if (duty_now != duty_goal) begin
              left = int'(duty_goal) - int'(duty_now);
              if (left < 0) left = -left;
              stp = $signed(step_amt);
              if (stp < 0) stp = -stp;
              if (left < stp) begin
                // less than one step left: close with the final step
                sum        = int'(duty_now) + $signed(last_step);
                duty_now   = sum[DutyW-1:0];
                duty_shown = duty_now;
                ramp_ph    = PH_ADJUSTED;
              end else begin
                sum        = int'(duty_now) + $signed(step_amt);
                duty_now   = sum[DutyW-1:0];
                duty_shown = duty_now;
                dwell_left = reg_dwell;
                ramp_ph    = PH_WAITING;
              end
            end else begin
              ramp_ph = PH_ADJUSTED;
            end
          end
          PH_WAITING: begin
            if (dwell_left == 0) ramp_ph = PH_ADJUSTING;
          end
          PH_ADJUSTED: begin
            ramp_ph = PH_IDLE;
            done    = 1'b1;
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (dwell_left != 0) dwell_left = dwell_left - 1'b1;
      end
      ACT_SET: begin
        delta     = int'(lvl) - int'(duty_now);
        duty_goal = lvl;
        if (delta != 0) begin
          // step is ceil(distance / span), final step is the remainder or a full step
          mag       = (delta < 0) ? -delta : delta;
          span      = (reg_span == 0) ? 1 : int'(reg_span);
          stp       = (mag + span - 1) / span;
          rem       = mag % stp;
          fin       = (rem == 0) ? stp : rem;
          stp       = (delta < 0) ? -stp : stp;
          fin       = (delta < 0) ? -fin : fin;
          step_amt  = stp[StepW-1:0];
          last_step = fin[StepW-1:0];
          ramp_ph   = PH_ADJUSTING;
        end
      end
      default: begin
        duty_now   = lvl;
        duty_goal  = lvl;
        duty_shown = lvl;
        step_amt   = '0;
        ramp_ph    = PH_IDLE;
      end
    endcase
    res.duty_level    = duty_shown;
    res.compare_value = (duty_shown > reg_scale) ? '0 : reg_scale - duty_shown;
    res.phase         = ramp_ph;
    res.finished      = done;
    return res;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DutyW-1:0] pick_level();
    if ($urandom_range(0, 99) < 80) return DutyW'($urandom_range(0, reg_scale));
    return DutyW'($urandom_range(0, 127));
  endfunction

  // well-formed ramp traffic steered by the predicted phase, with some upsets
  function automatic item_t pick_ramp_req(input int upset_pct);
    item_t it;
    int    r;
    r        = $urandom_range(0, 99);
    it.level = pick_level();
    if (r < upset_pct) begin
      it.action = action_t'($urandom_range(0, 3));
    end else begin
      r = $urandom_range(0, 99);
      case (ramp_ph)
        PH_IDLE:    it.action = (r < 75) ? ACT_SET : ((r < 90) ? ACT_UPDATE : ACT_TICK);
        PH_WAITING: it.action = (dwell_left != 0 && r < 92) ? ACT_TICK : ACT_UPDATE;
        default:    it.action = (r < 92) ? ACT_UPDATE : ACT_TICK;
      endcase
    end
    return it;
  endfunction

  // offer one request, hold it until taken, then maybe idle
  task automatic send_req(input item_t req);
    int gap;
    item       <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    owed_results.push_back(next_duty_result(req));
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(input action_t act, input int lvl);
    item_t it;
    it.action = act;
    it.level  = lvl[DutyW-1:0];
    send_req(it);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drain();
    item_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DWELL_TICKS: reg_dwell = val;
      CFG_STEP_SPAN:   reg_span  = val[DutyW-1:0];
      CFG_FULL_SCALE:  reg_scale = val[DutyW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input int dwell, input int span, input int scale);
    wait_drain();
    write_reg(CFG_DWELL_TICKS, CfgW'(dwell));
    write_reg(CFG_STEP_SPAN, CfgW'(span));
    write_reg(CFG_FULL_SCALE, CfgW'(scale));
  endtask

  // reset register values: idle requests, saturation, equal targets, mid-ramp init
  task automatic test_reset_defaults();
    send_op(ACT_TICK, 0);
    send_op(ACT_UPDATE, 127);
    send_op(ACT_INIT, 127);
    send_op(ACT_SET, 100);
    send_op(ACT_SET, 90);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_TICK, 0);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_SET, 99);
    send_op(ACT_INIT, 0);
    send_op(ACT_SET, 0);
    send_op(ACT_UPDATE, 0);
  endtask

  // zero span, zero dwell, and duty left above a lowered full scale
  task automatic test_zero_span_and_scale();
    wait_drain();
    write_reg(CFG_DWELL_TICKS, 8'd0);
    write_reg(CFG_STEP_SPAN, 8'd0);
    send_op(ACT_INIT, 50);
    send_op(ACT_SET, 13);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_SET, 20);
    send_op(ACT_UPDATE, 0);
    wait_drain();
    write_reg(CFG_FULL_SCALE, 8'd1);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_UPDATE, 0);
    send_op(ACT_INIT, 127);
  endtask

  // random ramps under one register setting
  task automatic test_ramp_walk(input int dwell, input int span, input int scale,
                                input int count, input int upset_pct);
    set_regs(dwell, span, scale);
    repeat (count) send_req(pick_ramp_req(upset_pct));
  endtask

  // long receiver hold while requests keep coming, then a full drain pause
  task automatic test_backpressure();
    set_regs(2, 9, 100);
    hold_req = 300;
    repeat (2) @(posedge clk);
    tx_quiet = 1'b1;
    repeat (40) send_req(pick_ramp_req(10));
    tx_quiet = 1'b0;
    wait_drain();
    repeat (20) send_req(pick_ramp_req(10));
  endtask

  // back-to-back traffic with neither side idling
  task automatic test_no_idle();
    wait_drain();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_ramp_walk(4, 20, 100, 150, 10);
    wait_drain();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // a few random register settings
  task automatic test_random_settings();
    repeat (2) begin
      test_ramp_walk($urandom_range(0, 6), $urandom_range(1, 100), $urandom_range(1, 100),
                     60, 12);
    end
  endtask

  // receiver stall pattern, with a long hold when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (rx_quiet) begin
      result_stall <= 1'b0;
    end else if (rx_burst > 0) begin
      result_stall <= 1'b1;
      rx_burst = rx_burst - 1;
    end else begin
      result_stall <= 1'b0;
      rx_burst = pick_gap();
    end
  end

  // compare each taken result with the oldest owed one
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (owed_results.size() == 0) begin
        bad_count++;
        if (bad_count <= MaxShown)
          $display("unexpected result: duty %0d cmp %0d phase %0d fin %0d",
                   result.duty_level, result.compare_value, result.phase, result.finished);
      end else begin
        want = owed_results.pop_front();
        if (result.duty_level !== want.duty_level ||
            result.compare_value !== want.compare_value ||
            result.phase !== want.phase || result.finished !== want.finished) begin
          bad_count++;
          if (bad_count <= MaxShown)
            $display("mismatch: expected duty %0d cmp %0d phase %0d fin %0d, got %0d %0d %0d %0d",
                     want.duty_level, want.compare_value, want.phase, want.finished,
                     result.duty_level, result.compare_value, result.phase, result.finished);
        end
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_span_and_scale();
    test_ramp_walk(3, 5, 100, 250, 12);
    test_ramp_walk(0, 1, 100, 120, 12);
    test_ramp_walk(1, 100, 100, 220, 8);
    test_ramp_walk(255, 1, 60, 280, 0);
    test_ramp_walk(2, 7, 1, 60, 12);
    test_backpressure();
    test_no_idle();
    test_random_settings();
    wait_drain();
    repeat (30) @(posedge clk);
    if (bad_count == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
